FILE: sv/extrinsic_curvature_cell_defines.svh
// ----------------------------------------------------------------------------
// extrinsic curvature cell assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef EXTRINSIC_CURVATURE_CELL_DEFINES_SVH
`define EXTRINSIC_CURVATURE_CELL_DEFINES_SVH
`ifndef SYNTHESIS
`define ECC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ECC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ECC_ASSERT_IMPL(label, ante, cons)
`define ECC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// shared types and constants of the extrinsic curvature cell
// ----------------------------------------------------------------------------
package ecc_pkg;
  localparam int NSLOTS     = 58;
  localparam int SLOT_GAMMA = 18;
  localparam int SLOT_SHIFT = 45;
  localparam int SLOT_LAPSE = 48;
  localparam int SLOT_DGT   = 49;
  localparam int SLOT_W     = 6;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 48;
  localparam int WIDE_W     = 72;
  localparam int CFG_AW     = 4;

  localparam logic [CFG_AW-1:0] REG_DX = 4'd0;
  localparam logic [CFG_AW-1:0] REG_DY = 4'd4;
  localparam logic [CFG_AW-1:0] REG_DZ = 4'd8;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_RDB   = 8'b0000_0010,
    ST_MDB   = 8'b0000_0100,
    ST_RG    = 8'b0000_1000,
    ST_MG    = 8'b0001_0000,
    ST_NUM   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;
endpackage

FILE: sv/ecc_if.sv
// ----------------------------------------------------------------------------
// ecc_in_if / ecc_out_if
// valid/ready channels of the extrinsic curvature cell
// ----------------------------------------------------------------------------
interface ecc_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  slot;
  logic signed [31:0] value;
  logic        last;
  modport source (output valid, slot, value, last, input ready);
  modport sink (input valid, slot, value, last, output ready);
endinterface

interface ecc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row;
  logic [1:0]  col;
  logic signed [31:0] curvature;
  logic        bad_lapse;
  logic        end_of_run;
  modport source (output valid, row, col, curvature, bad_lapse, end_of_run, input ready);
  modport sink (input valid, row, col, curvature, bad_lapse, end_of_run, output ready);
endinterface

FILE: sv/extrinsic_curvature_cell.sv
// ----------------------------------------------------------------------------
// extrinsic_curvature_cell
// Loads 58 operand words, one a cycle, then works out the nine curvature
// entries with registered multiplies and a bit-serial radix-2 divider. A
// run after the last word first forms the shift derivatives, then the
// contraction. Each entry then takes a numerator step, the divide and an
// output step that waits while the previous output is not yet taken. Not
// ready to load until the run ends.
// ----------------------------------------------------------------------------
`include "extrinsic_curvature_cell_defines.svh"
module extrinsic_curvature_cell
  import ecc_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int DIMS      = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  ecc_in_if.sink             in_ch,
  ecc_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  localparam int NE = DIMS * DIMS;
  localparam int IW = $clog2(NE + 1);
  localparam int DW = 7;

  logic [30:0] inv_r [DIMS];
  logic signed [VAL_W-1:0] mem [NSLOTS];
  state_t state_r;
  logic [IW-1:0] idx_r;
  logic [1:0]    cc_r;
  logic [DW-1:0] dcnt_r;
  logic [5:0]    ra_r, rb_r;
  logic signed [VAL_W-1:0] rda_r, rdb_r;
  logic signed [63:0] prod_r;
  logic signed [ACC_W-1:0] gacc_r [NE];
  logic signed [WIDE_W-1:0] db_r [NE];
  logic signed [WIDE_W-1:0] num_r;
  logic [63:0] rem_r, quo_r;
  logic [31:0] den_r;
  logic neg_r, zlap_r, sat_r, pend_r;
  logic [1:0] ar, br;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIMS; i++) inv_r[i] <= 31'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        REG_DX: inv_r[0] <= cfg_pwdata[30:0];
        REG_DY: inv_r[1] <= cfg_pwdata[30:0];
        REG_DZ: inv_r[2] <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_DX:  cfg_prdata = {1'b0, inv_r[0]};
      REG_DY:  cfg_prdata = {1'b0, inv_r[1]};
      REG_DZ:  cfg_prdata = {1'b0, inv_r[2]};
      default: cfg_prdata = '0;
    endcase
  end

  logic in_acc;
  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc = in_ch.valid && in_ch.ready;

  // dB pass: idx = 3c+a ; G pass: idx = 3a+b, cc = c
  always_comb begin
    if (idx_r >= IW'(6)) begin
      ar = 2'd2; br = 2'(idx_r - IW'(6));
    end else if (idx_r >= IW'(3)) begin
      ar = 2'd1; br = 2'(idx_r - IW'(3));
    end else begin
      ar = 2'd0; br = 2'(idx_r);
    end
  end

  function automatic logic signed [WIDE_W-1:0] fshift(input logic signed [63:0] p);
    fshift = WIDE_W'(p >>> FRAC_BITS);
  endfunction

  logic signed [ACC_W:0] gsum;
  logic signed [ACC_W-1:0] gsat;
  always_comb begin
    gsum = (ACC_W+1)'(gacc_r[idx_r]) + (ACC_W+1)'(prod_r >>> FRAC_BITS);
    if (gsum[ACC_W] != gsum[ACC_W-1])
      gsat = gsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    else
      gsat = gsum[ACC_W-1:0];
  end

  logic signed [WIDE_W-1:0] corr, numv;
  logic [WIDE_W-1:0] nmag;
  logic [IW-1:0] tidx;
  always_comb begin
    tidx = IW'(br * 3 + ar);
    corr = db_r[idx_r] + db_r[tidx] - (WIDE_W'(gacc_r[idx_r]) <<< 1);
    numv = WIDE_W'(rda_r) - corr;
    nmag = numv[WIDE_W-1] ? WIDE_W'(-numv) : WIDE_W'(numv);
  end

  logic [64:0] rtry;
  assign rtry = {rem_r, quo_r[63]} - {33'd0, den_r};
  logic [31:0] lim, mag;
  always_comb begin
    lim = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (zlap_r) mag = (num_r == 0) ? 32'd0 : (num_r > 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
    else if (sat_r || quo_r > {32'd0, lim}) mag = lim;
    else mag = quo_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.slot < SLOT_W'(NSLOTS)) mem[in_ch.slot] <= in_ch.value;
    rda_r <= mem[ra_r];
    rdb_r <= mem[rb_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r <= '0; cc_r <= '0; dcnt_r <= '0; pend_r <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < NE; i++) gacc_r[i] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state_r)
        ST_LOAD: if (in_acc && in_ch.last) begin
          state_r <= ST_RDB; idx_r <= '0; pend_r <= 1'b0;
        end
        ST_RDB: begin
          ra_r <= 6'(6 * ar + 2 * br);
          rb_r <= 6'(6 * ar + 2 * br + 1);
          state_r <= pend_r ? ST_MDB : ST_RDB;
          pend_r <= ~pend_r;
        end
        ST_MDB: begin
          prod_r <= 64'((65'(rda_r) - 65'(rdb_r)) * $signed({1'b0, inv_r[br]}));
          pend_r <= 1'b0;
          state_r <= ST_MG;
          cc_r <= 2'd3;
        end
        ST_MG: begin
          if (cc_r == 2'd3) begin
            db_r[idx_r] <= fshift(prod_r);
            if (idx_r == IW'(NE - 1)) begin
              idx_r <= '0; cc_r <= '0; state_r <= ST_RG;
            end else begin
              idx_r <= idx_r + 1'b1; state_r <= ST_RDB;
            end
          end else begin
            gacc_r[idx_r] <= (cc_r == 2'd0) ? ACC_W'(prod_r >>> FRAC_BITS) : gsat;
            if (cc_r == 2'd2) begin
              if (idx_r == IW'(NE - 1)) begin
                idx_r <= '0; cc_r <= '0; state_r <= ST_NUM; pend_r <= 1'b0;
              end else begin
                idx_r <= idx_r + 1'b1; cc_r <= '0; state_r <= ST_RG;
              end
            end else begin
              cc_r <= cc_r + 1'b1; state_r <= ST_RG;
            end
          end
        end
        ST_RG: begin
          ra_r <= 6'(SLOT_GAMMA + 3 * idx_r + cc_r);
          rb_r <= 6'(SLOT_SHIFT + cc_r);
          if (pend_r) begin
            state_r <= ST_DIV; pend_r <= 1'b0; dcnt_r <= '1;
          end else pend_r <= 1'b1;
        end
        ST_DIV: if (dcnt_r == '1) begin
          prod_r <= rda_r * rdb_r;
          state_r <= ST_MG;
        end else begin
          if (!rtry[64]) begin
            rem_r <= rtry[63:0]; quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], quo_r[63]}; quo_r <= {quo_r[62:0], 1'b0};
          end
          if (dcnt_r == '0) state_r <= ST_OUT;
          else dcnt_r <= dcnt_r - 1'b1;
        end
        ST_NUM: begin
          ra_r <= 6'(SLOT_DGT + idx_r);
          rb_r <= 6'(SLOT_LAPSE);
          if (cc_r == 2'd2) begin
            cc_r <= '0;
            num_r <= numv;
            zlap_r <= (rdb_r == 0);
            den_r <= rdb_r[31] ? 32'(-rdb_r) : 32'(rdb_r);
            neg_r <= (numv > 0) == (rdb_r > 0);
            sat_r <= nmag >= (WIDE_W'(1) << (64 - FRAC_BITS + 1));
            quo_r <= 64'(nmag << (FRAC_BITS - 1));
            rem_r <= '0;
            dcnt_r <= DW'(63);
            state_r <= ST_DIV;
          end else cc_r <= cc_r + 1'b1;
        end
        ST_OUT: if (!out_ch.valid) begin
          out_ch.valid <= 1'b1;
          out_ch.row <= ar; out_ch.col <= br;
          out_ch.curvature <= (neg_r && !zlap_r) ? 32'(-mag) : mag;
          out_ch.bad_lapse <= zlap_r;
          out_ch.end_of_run <= (idx_r == IW'(NE - 1));
          if (idx_r == IW'(NE - 1)) state_r <= ST_LOAD;
          else begin
            idx_r <= idx_r + 1'b1; cc_r <= '0; state_r <= ST_NUM;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  `ECC_ASSERT_IMPL(a_rdy_load, in_ch.ready, state_r == ST_LOAD)
  `ECC_ASSERT_IMPL(a_idx_rng, 1'b1, idx_r < IW'(NE))
  `ECC_ASSERT_NEXT(a_end_load, out_ch.valid && out_ch.ready && out_ch.end_of_run, !out_ch.valid)
endmodule
